[rtl/qpd_pkg.sv]
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared types, constants and the microcode table of the quantized PD map
// stepper.
// ----------------------------------------------------------------------------
package qpd_pkg;

  // data widths
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CTRL_W     = 12;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned CFG_ADDR_W = 8;
  localparam int unsigned STEP_W     = 4;

  // defaults for the top level parameters
  localparam int unsigned ROUND_AT_INPUT_DEF = 0;
  localparam int unsigned FRAC_BITS_DEF      = 20;

  typedef logic signed [DATA_W-1:0] word_t;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    RG_U_PP,
    RG_U_PV,
    RG_U_VP,
    RG_U_VV,
    RG_B_POS,
    RG_B_VEL,
    RG_P_GAIN,
    RG_D_GAIN
  } reg_idx_e;

  // second multiplier operand
  typedef enum logic [2:0] {
    OPB_POS,
    OPB_VEL,
    OPB_IPOS,
    OPB_IVEL,
    OPB_CTRL,
    OPB_M
  } opb_e;

  // accumulator operation on the previous product
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  // side action of a step
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CTRL,
    ACT_NPOS,
    ACT_ITER_DONE,
    ACT_LOAD_DONE
  } act_e;

  typedef enum logic {
    JMP_NONE,
    JMP_IF_LOAD
  } jmp_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_e;

  localparam logic [STEP_W-1:0] STEP_DISPATCH = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_LOAD     = STEP_W'(10);

  // one control word
  typedef struct packed {
    reg_idx_e          mul_a;
    opb_e              mul_b;
    acc_op_e           acc_op;
    logic              acc_shift;
    act_e              act;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } uword_t;

  // sequencer to datapath control
  typedef struct packed {
    uword_t uw;
    logic   fire;
    logic   accept;
  } dp_ctl_t;

  // microcode rom; rai selects the round-at-input program
  function automatic uword_t ucode(input logic [STEP_W-1:0] step, input logic rai);
    uword_t w;
    logic   sd;
    opb_e   op_p;
    opb_e   op_v;
    opb_e   op_b;
    sd   = !rai;
    op_p = rai ? OPB_IPOS : OPB_POS;
    op_v = rai ? OPB_IVEL : OPB_VEL;
    op_b = rai ? OPB_M : OPB_CTRL;
    unique case (step)
      STEP_DISPATCH: w = '{RG_P_GAIN, op_p, ACC_HOLD, 1'b0, ACT_NONE, JMP_IF_LOAD, STEP_LOAD};
      STEP_W'(1):    w = '{RG_D_GAIN, op_v, ACC_LOAD, sd, ACT_NONE, JMP_NONE, STEP_DISPATCH};
      STEP_W'(2):    w = '{RG_U_PP, OPB_POS, ACC_ADD, sd, ACT_NONE, JMP_NONE, STEP_DISPATCH};
      STEP_W'(3):    w = '{RG_U_PV, OPB_VEL, ACC_LOAD, 1'b1, ACT_CTRL, JMP_NONE, STEP_DISPATCH};
      STEP_W'(4):    w = '{RG_B_POS, op_b, ACC_ADD, 1'b1, ACT_NONE, JMP_NONE, STEP_DISPATCH};
      STEP_W'(5):    w = '{RG_U_VP, OPB_POS, ACC_ADD, rai, ACT_NONE, JMP_NONE, STEP_DISPATCH};
      STEP_W'(6):    w = '{RG_U_VV, OPB_VEL, ACC_LOAD, 1'b1, ACT_NPOS, JMP_NONE, STEP_DISPATCH};
      STEP_W'(7):    w = '{RG_B_VEL, op_b, ACC_ADD, 1'b1, ACT_NONE, JMP_NONE, STEP_DISPATCH};
      STEP_W'(8):    w = '{RG_U_PP, OPB_POS, ACC_ADD, rai, ACT_NONE, JMP_NONE, STEP_DISPATCH};
      STEP_W'(9):    w = '{RG_U_PP, OPB_POS, ACC_HOLD, 1'b0, ACT_ITER_DONE, JMP_NONE,
                           STEP_DISPATCH};
      STEP_LOAD:     w = '{RG_U_PP, OPB_POS, ACC_HOLD, 1'b0, ACT_LOAD_DONE, JMP_NONE,
                           STEP_DISPATCH};
      default:       w = '{RG_U_PP, OPB_POS, ACC_HOLD, 1'b0, ACT_ITER_DONE, JMP_NONE,
                           STEP_DISPATCH};
    endcase
    return w;
  endfunction

endpackage

[rtl/qpd_if.sv]
// ----------------------------------------------------------------------------
// qpd_if
// Valid/ready channels of the quantized PD map stepper: item input, result
// output and configuration write.
// ----------------------------------------------------------------------------

// input items
interface qpd_in_if;
  import qpd_pkg::*;
  logic  valid;
  logic  ready;
  logic  func;
  word_t load_pos;
  word_t load_vel;
  modport source (output valid, func, load_pos, load_vel, input ready);
  modport sink (input valid, func, load_pos, load_vel, output ready);
endinterface

// result items
interface qpd_out_if;
  import qpd_pkg::*;
  logic                     valid;
  logic                     ready;
  word_t                    pos_out;
  word_t                    vel_out;
  logic signed [CTRL_W-1:0] control_level;
  logic                     saturated;
  modport source (output valid, pos_out, vel_out, control_level, saturated, input ready);
  modport sink (input valid, pos_out, vel_out, control_level, saturated, output ready);
endinterface

// configuration writes
interface qpd_cfg_if;
  import qpd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  word_t                 data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/qpd_cfg_regs.sv]
// ----------------------------------------------------------------------------
// qpd_cfg_regs
// Configuration register file: transition matrix, control vector and gains.
// Writes to indexes past the last register are dropped.
// ----------------------------------------------------------------------------
module qpd_cfg_regs #(
  parameter int unsigned FRAC_BITS = qpd_pkg::FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  qpd_cfg_if.sink       cfg_i,
  output qpd_pkg::word_t regs_o [qpd_pkg::NUM_REGS]
);
  import qpd_pkg::*;

  localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(1) << FRAC_BITS;

  word_t regs_q [NUM_REGS];
  logic  wr_en;

  // always ready, writes are meant for idle time only
  assign cfg_i.ready = 1'b1;
  assign wr_en = cfg_i.valid && cfg_i.ready && (cfg_i.index < CFG_ADDR_W'(NUM_REGS));

  // register storage, identity matrix on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_q[i] <= '0;
      end
      regs_q[RG_U_PP] <= ONE_FX;
      regs_q[RG_U_VV] <= ONE_FX;
    end else if (wr_en) begin
      regs_q[cfg_i.index[REG_IDX_W-1:0]] <= cfg_i.data;
    end
  end

  assign regs_o = regs_q;

endmodule

[rtl/qpd_useq.sv]
// ----------------------------------------------------------------------------
// qpd_useq
// Microcode sequencer: step counter, dispatch jump on the item function,
// control word fetch and the result valid flag.
// ----------------------------------------------------------------------------
module qpd_useq #(
  parameter int unsigned ROUND_AT_INPUT = qpd_pkg::ROUND_AT_INPUT_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_func_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output qpd_pkg::dp_ctl_t ctl_o
);
  import qpd_pkg::*;

  seq_state_e        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              func_q;
  logic              out_valid_q, out_valid_d;
  uword_t            uw;
  logic              in_acc;
  logic              finishing;
  logic              stall;
  logic              fire;
  logic              jump;

  // control word fetch
  assign uw        = ucode(step_q, 1'(ROUND_AT_INPUT));
  assign in_acc    = in_valid_i && in_ready_o;
  assign finishing = (uw.act == ACT_ITER_DONE) || (uw.act == ACT_LOAD_DONE);
  assign stall     = finishing && out_valid_q && !out_ready_i;
  assign jump      = (uw.jmp == JMP_IF_LOAD) && !func_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RUN;
      ST_RUN:  if (fire && finishing) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready_o = 1'b0;
    fire       = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_RUN:  fire = !stall;
      default: ;
    endcase
  end

  // step counter with conditional jump
  always_comb begin
    step_d = step_q;
    if (in_acc) begin
      step_d = STEP_DISPATCH;
    end else if (fire) begin
      step_d = jump ? uw.target : step_q + 1'b1;
    end
  end

  // result slot: set on finish, freed when taken
  assign out_valid_d = (fire && finishing) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= STEP_DISPATCH;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // function of the request in flight
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= in_func_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign ctl_o       = '{uw: uw, fire: fire, accept: in_acc};

  // a finished item always shows up in the result slot
  a_finish_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && finishing) |=> out_valid_q)
    else $error("finished item not presented");

  // an accepted request starts at the dispatch step
  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RUN && step_q == STEP_DISPATCH))
    else $error("request did not start at dispatch");

  // the step counter stays inside the program
  a_step_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= STEP_LOAD))
    else $error("step counter left the program");

  // a blocked finish keeps its step and stays busy
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && stall) |=> (state_q == ST_RUN && step_q == $past(step_q)))
    else $error("stalled finish lost its step");

endmodule

[rtl/qpd_datapath.sv]
// ----------------------------------------------------------------------------
// qpd_datapath
// Shared 32x32 multiplier, 64-bit accumulator, control quantizer,
// saturation and state / result registers, driven by the control word.
// ----------------------------------------------------------------------------
module qpd_datapath #(
  parameter int unsigned ROUND_AT_INPUT = qpd_pkg::ROUND_AT_INPUT_DEF,
  parameter int unsigned FRAC_BITS      = qpd_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  qpd_pkg::dp_ctl_t                 ctl_i,
  input  qpd_pkg::word_t                   regs_i [qpd_pkg::NUM_REGS],
  input  qpd_pkg::word_t                   load_pos_i,
  input  qpd_pkg::word_t                   load_vel_i,
  output qpd_pkg::word_t                   pos_out_o,
  output qpd_pkg::word_t                   vel_out_o,
  output logic signed [qpd_pkg::CTRL_W-1:0] control_level_o,
  output logic                             saturated_o
);
  import qpd_pkg::*;

  localparam int unsigned DW1 = DATA_W + 1;
  localparam logic signed [DATA_W:0]    BIAS_D = DW1'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [ACC_W-1:0]   BIAS_A = ACC_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [DATA_W-1:0]  MAX_W  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0]  MIN_W  = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [CTRL_W-1:0]  MAX_C  = {1'b0, {(CTRL_W-1){1'b1}}};
  localparam logic signed [CTRL_W-1:0]  MIN_C  = {1'b1, {(CTRL_W-1){1'b0}}};

  word_t                    pos_q, vel_q;
  word_t                    ld_pos_q, ld_vel_q;
  word_t                    m_q, np_q;
  logic signed [CTRL_W-1:0] ctrl_q;
  logic                     sat_q;
  logic signed [ACC_W-1:0]  prod_q, acc_q;
  word_t                    pos_out_q, vel_out_q;
  logic signed [CTRL_W-1:0] ctrl_out_q;
  logic                     sat_out_q;

  word_t                    opa, opb;
  logic signed [DATA_W:0]   ipos_sum, ivel_sum, ipos_w, ivel_w;
  logic signed [ACC_W-1:0]  prod_d, term, acc_d;
  logic                     acc_fits;
  word_t                    acc_clip;
  logic signed [ACC_W-1:0]  ctl_src, ctl_sum, ctl_tr;
  logic                     ctl_fits;
  logic signed [CTRL_W-1:0] ctrl_d;
  logic                     ctl_sat;

  // state components truncated toward zero
  always_comb begin
    ipos_sum = {pos_q[DATA_W-1], pos_q} + (pos_q[DATA_W-1] ? BIAS_D : '0);
    ivel_sum = {vel_q[DATA_W-1], vel_q} + (vel_q[DATA_W-1] ? BIAS_D : '0);
    ipos_w   = ipos_sum >>> FRAC_BITS;
    ivel_w   = ivel_sum >>> FRAC_BITS;
  end

  // multiplier operands
  assign opa = regs_i[ctl_i.uw.mul_a];

  always_comb begin
    case (ctl_i.uw.mul_b)
      OPB_POS:  opb = pos_q;
      OPB_VEL:  opb = vel_q;
      OPB_IPOS: opb = ipos_w[DATA_W-1:0];
      OPB_IVEL: opb = ivel_w[DATA_W-1:0];
      OPB_CTRL: opb = DATA_W'(ctrl_q);
      OPB_M:    opb = m_q;
      default:  opb = pos_q;
    endcase
  end

  assign prod_d = opa * opb;

  // accumulate the previous product, floored after the shift
  always_comb begin
    term = ctl_i.uw.acc_shift ? (prod_q >>> FRAC_BITS) : prod_q;
    case (ctl_i.uw.acc_op)
      ACC_LOAD: acc_d = term;
      ACC_ADD:  acc_d = acc_q + term;
      default:  acc_d = acc_q;
    endcase
  end

  // accumulator clipped to the word range
  always_comb begin
    acc_fits = (acc_q[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){acc_q[ACC_W-1]}});
    acc_clip = acc_fits ? acc_q[DATA_W-1:0] : (acc_q[ACC_W-1] ? MIN_W : MAX_W);
  end

  // control level: truncate toward zero, then clip to the level range
  always_comb begin
    ctl_src  = (ROUND_AT_INPUT != 0) ? ACC_W'(acc_clip) : acc_q;
    ctl_sum  = ctl_src + (ctl_src[ACC_W-1] ? BIAS_A : '0);
    ctl_tr   = ctl_sum >>> FRAC_BITS;
    ctl_fits = (ctl_tr[ACC_W-1:CTRL_W-1] == {(ACC_W-CTRL_W+1){ctl_tr[ACC_W-1]}});
    ctrl_d   = ctl_fits ? ctl_tr[CTRL_W-1:0] : (ctl_tr[ACC_W-1] ? MIN_C : MAX_C);
    ctl_sat  = !ctl_fits || ((ROUND_AT_INPUT != 0) && !acc_fits);
  end

  // map state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vel_q <= '0;
    end else if (ctl_i.fire) begin
      if (ctl_i.uw.act == ACT_ITER_DONE) begin
        pos_q <= np_q;
        vel_q <= acc_clip;
      end else if (ctl_i.uw.act == ACT_LOAD_DONE) begin
        pos_q <= ld_pos_q;
        vel_q <= ld_vel_q;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      ld_pos_q <= load_pos_i;
      ld_vel_q <= load_vel_i;
      sat_q    <= 1'b0;
    end
    if (ctl_i.fire) begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
      case (ctl_i.uw.act)
        ACT_CTRL: begin
          ctrl_q <= ctrl_d;
          m_q    <= acc_clip;
          if (ctl_sat) sat_q <= 1'b1;
        end
        ACT_NPOS: begin
          np_q <= acc_clip;
          if (!acc_fits) sat_q <= 1'b1;
        end
        ACT_ITER_DONE: begin
          pos_out_q  <= np_q;
          vel_out_q  <= acc_clip;
          ctrl_out_q <= ctrl_q;
          sat_out_q  <= sat_q || !acc_fits;
        end
        ACT_LOAD_DONE: begin
          pos_out_q  <= ld_pos_q;
          vel_out_q  <= ld_vel_q;
          ctrl_out_q <= '0;
          sat_out_q  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign pos_out_o       = pos_out_q;
  assign vel_out_o       = vel_out_q;
  assign control_level_o = ctrl_out_q;
  assign saturated_o     = sat_out_q;

endmodule

[rtl/quantized_pd_map_step_top.sv]
// ----------------------------------------------------------------------------
// quantized_pd_map_step_top
// Iterates the map of a PD-controlled inverted pendulum with quantized
// control, y' = U*y + b*M, in signed fixed point with FRAC_BITS fraction bits.
//
// A request with func 0 loads position and velocity; func 1 runs one map
// iteration. Every request gives one result: the new state, the integer
// control level and a flag for any clipping. One request is worked on at a
// time and the next is taken once the previous one has gone to the result
// register. A result that is still waiting holds the next request at its
// last step until the slot frees up. The iteration length is set by the
// single shared 32x32 multiplier, which forms the eight products of a step
// one per cycle under a ten-step microcode program. ROUND_AT_INPUT = 1
// truncates the state before the gain products instead of truncating their
// sum. There is no clearing pass after reset; configuration writes are taken
// at any time but belong to idle time.
// ----------------------------------------------------------------------------
module quantized_pd_map_step_top #(
  parameter int unsigned ROUND_AT_INPUT = qpd_pkg::ROUND_AT_INPUT_DEF,
  parameter int unsigned FRAC_BITS      = qpd_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qpd_cfg_if.sink    cfg_i,
  qpd_in_if.sink     in_i,
  qpd_out_if.source  out_o
);
  import qpd_pkg::*;

  word_t   regs [NUM_REGS];
  dp_ctl_t ctl;

  // configuration registers
  qpd_cfg_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  // microcode sequencer
  qpd_useq #(
    .ROUND_AT_INPUT (ROUND_AT_INPUT)
  ) u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_func_i   (in_i.func),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .ctl_o       (ctl)
  );

  // arithmetic datapath
  qpd_datapath #(
    .ROUND_AT_INPUT (ROUND_AT_INPUT),
    .FRAC_BITS      (FRAC_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .regs_i          (regs),
    .load_pos_i      (in_i.load_pos),
    .load_vel_i      (in_i.load_vel),
    .pos_out_o       (out_o.pos_out),
    .vel_out_o       (out_o.vel_out),
    .control_level_o (out_o.control_level),
    .saturated_o     (out_o.saturated)
  );

endmodule

[tb/tb_quantized_pd_map_step_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quantized_pd_map_step_top
// Self-checking bench for the quantized PD map stepper. A queue of pending
// requests feeds a valid/ready driver. At each accepted request a fixed-point
// model of the pendulum map works out the next state, the control level and
// the clip flag. A monitor compares every result with the oldest prediction.
// Phases cover several register settings and several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_quantized_pd_map_step_top;
  import qpd_pkg::*;

  localparam int unsigned FB          = FRAC_BITS_DEF;
  localparam bit          RAI         = (ROUND_AT_INPUT_DEF != 0);
  localparam int          ONE         = 1 << FB;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned LIMIT       = 500000;
  localparam int          NUM_PHASES  = 6;

  localparam longint signed W_MAX = 64'sd2147483647;
  localparam longint signed W_MIN = -64'sd2147483648;
  localparam longint signed L_MAX = 64'sd2047;
  localparam longint signed L_MIN = -64'sd2048;

  // request function codes
  localparam logic FN_LOAD = 1'b0;
  localparam logic FN_ITER = 1'b1;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic  func;
    word_t pos;
    word_t vel;
  } map_req_t;

  typedef struct {
    word_t                    pos;
    word_t                    vel;
    logic signed [CTRL_W-1:0] lvl;
    logic                     sat;
  } map_state_t;

  logic clk_i;
  logic rst_ni;

  qpd_in_if  in_if ();
  qpd_out_if out_if ();
  qpd_cfg_if cfg_if ();

  quantized_pd_map_step_top #(
    .ROUND_AT_INPUT(ROUND_AT_INPUT_DEF),
    .FRAC_BITS     (FB)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // model state and register copy
  word_t coef [NUM_REGS];
  word_t plan [NUM_REGS];
  word_t cur_pos;
  word_t cur_vel;

  map_req_t   req_q [$];
  map_state_t next_state_q [$];
  map_req_t   cur_req;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_kick = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned n_errors = 0;
  int unsigned n_loads = 0;
  int unsigned n_iters = 0;
  int unsigned n_clipped = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // fixed-point helpers
  function automatic longint signed fx_mul(longint signed a, longint signed b);
    return (a * b) >>> FB;
  endfunction

  function automatic longint signed trunc_int(longint signed x);
    return (x < 0) ? -((-x) >>> FB) : (x >>> FB);
  endfunction

  function automatic longint signed clamp(longint signed v, longint signed lo,
                                          longint signed hi, inout bit flag);
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < lo) begin
      flag = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint signed cf(reg_idx_e i);
    return coef[i];
  endfunction

  function automatic word_t fx(int num, int den);
    return word_t'((longint'(num) <<< FB) / den);
  endfunction

  // next state of the pendulum map for one request
  function automatic map_state_t predict_map_step(map_req_t r);
    map_state_t    res;
    longint signed pos, vel, dot, m, lvl, bp, bv, np, nv;
    bit            clip_f;
    clip_f = 1'b0;
    lvl    = 0;
    if (r.func == FN_LOAD) begin
      cur_pos = r.pos;
      cur_vel = r.vel;
    end else begin
      pos = cur_pos;
      vel = cur_vel;
      if (RAI) begin
        // truncate the state first, then apply the gains
        m   = cf(RG_P_GAIN) * trunc_int(pos) + cf(RG_D_GAIN) * trunc_int(vel);
        m   = clamp(m, W_MIN, W_MAX, clip_f);
        lvl = clamp(trunc_int(m), L_MIN, L_MAX, clip_f);
        bp  = fx_mul(cf(RG_B_POS), m);
        bv  = fx_mul(cf(RG_B_VEL), m);
      end else begin
        // truncate the gain dot product to an integer level
        dot = fx_mul(cf(RG_P_GAIN), pos) + fx_mul(cf(RG_D_GAIN), vel);
        lvl = clamp(trunc_int(dot), L_MIN, L_MAX, clip_f);
        bp  = cf(RG_B_POS) * lvl;
        bv  = cf(RG_B_VEL) * lvl;
      end
      np = fx_mul(cf(RG_U_PP), pos) + fx_mul(cf(RG_U_PV), vel) + bp;
      nv = fx_mul(cf(RG_U_VP), pos) + fx_mul(cf(RG_U_VV), vel) + bv;
      cur_pos = word_t'(clamp(np, W_MIN, W_MAX, clip_f));
      cur_vel = word_t'(clamp(nv, W_MIN, W_MAX, clip_f));
    end
    res.pos = cur_pos;
    res.vel = cur_vel;
    res.lvl = CTRL_W'(lvl);
    res.sat = clip_f;
    return res;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        next_state_q.push_back(predict_map_step(cur_req));
        if (cur_req.func == FN_LOAD) n_loads++;
        else n_iters++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = req_q.pop_front();
          in_if.valid    <= 1'b1;
          in_if.func     <= cur_req.func;
          in_if.load_pos <= cur_req.pos;
          in_if.load_vel <= cur_req.vel;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_kick) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk_i) begin
    map_state_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (next_state_q.size() == 0) begin
          n_errors++;
          $display("%t unexpected result: got pos %h vel %h lvl %0d sat %b", $time,
                   out_if.pos_out, out_if.vel_out, out_if.control_level,
                   out_if.saturated);
        end else begin
          want = next_state_q.pop_front();
          if (out_if.saturated) n_clipped++;
          if (out_if.pos_out !== want.pos || out_if.vel_out !== want.vel ||
              out_if.control_level !== want.lvl || out_if.saturated !== want.sat) begin
            n_errors++;
            $display("%t mismatch: expected pos %h vel %h lvl %0d sat %b", $time,
                     want.pos, want.vel, want.lvl, want.sat);
            $display("%t           actual   pos %h vel %h lvl %0d sat %b", $time,
                     out_if.pos_out, out_if.vel_out, out_if.control_level,
                     out_if.saturated);
          end
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               next_state_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_req(input logic func, input word_t pos, input word_t vel);
    map_req_t r;
    r.func = func;
    r.pos  = pos;
    r.vel  = vel;
    req_q.push_back(r);
  endtask

  // wait until every request is taken and every result has come back
  task automatic wait_idle();
    do @(negedge clk_i);
    while (req_q.size() != 0 || in_if.valid || next_state_q.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input word_t val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i);
    while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx < NUM_REGS) coef[idx[REG_IDX_W-1:0]] = val;
  endtask

  task automatic apply_plan();
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_ADDR_W'(i), plan[i]);
  endtask

  function automatic word_t rand_signed(int unsigned r);
    return word_t'($urandom_range(0, 2 * r)) - word_t'(r);
  endfunction

  // state values from small to full range, extremes included
  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(3))
      0: w = $urandom;
      1: w = rand_signed(1 << 24);
      2: begin
        case ($urandom_range(4))
          0: w = word_t'(W_MAX);
          1: w = word_t'(W_MIN);
          2: w = '0;
          3: w = 32'sd1;
          default: w = -32'sd1;
        endcase
      end
      default: w = rand_signed(1 << 28);
    endcase
    return w;
  endfunction

  function automatic word_t rand_coef();
    word_t w;
    case ($urandom_range(3))
      0: w = $urandom;
      1: w = word_t'(ONE) + rand_signed(ONE / 8);
      2: w = rand_signed(ONE / 2);
      default: begin
        case ($urandom_range(4))
          0: w = word_t'(W_MAX);
          1: w = word_t'(W_MIN);
          2: w = '0;
          3: w = word_t'(ONE);
          default: w = -word_t'(ONE);
        endcase
      end
    endcase
    return w;
  endfunction

  // a mildly unstable pendulum held by the feedback, with gains varied a bit
  task automatic pendulum_plan();
    plan[RG_U_PP]   = fx(102, 100);
    plan[RG_U_PV]   = fx(5, 100);
    plan[RG_U_VP]   = fx(40, 100);
    plan[RG_U_VV]   = fx(102, 100);
    plan[RG_B_POS]  = -fx(1, 1000);
    plan[RG_B_VEL]  = -fx(5, 100);
    plan[RG_P_GAIN] = fx(1, 1) + rand_signed(ONE / 2);
    plan[RG_D_GAIN] = fx(1, 2) + rand_signed(ONE / 4);
  endtask

  // mostly load-then-iterate runs, some lone requests as noise
  task automatic gen_burst(input int n);
    int cnt;
    int run;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 85) begin
        push_req(FN_LOAD, rand_word(), rand_word());
        run = $urandom_range(1, 24);
        repeat (run) push_req(FN_ITER, $urandom, $urandom);
        cnt += run + 1;
      end else begin
        push_req(1'($urandom), rand_word(), $urandom);
        cnt++;
      end
    end
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 74; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 74; end
      default:   begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
  endtask

  // main sequence
  initial begin
    int n_settings;
    n_settings      = 1;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.func      = FN_LOAD;
    in_if.load_pos  = '0;
    in_if.load_vel  = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    cur_pos         = '0;
    cur_vel         = '0;
    for (int i = 0; i < NUM_REGS; i++) coef[i] = '0;
    coef[RG_U_PP] = word_t'(ONE);
    coef[RG_U_VV] = word_t'(ONE);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: identity map, no control
    push_req(FN_ITER, '0, '0);
    push_req(FN_LOAD, word_t'(W_MAX), word_t'(W_MAX));
    push_req(FN_ITER, '0, '0);
    push_req(FN_LOAD, word_t'(W_MIN), word_t'(W_MIN));
    push_req(FN_ITER, '1, '1);
    push_req(FN_LOAD, '0, -32'sd1);
    push_req(FN_ITER, '0, '0);
    wait_idle();

    // all registers at the top of the range: state overflow both ways
    for (int i = 0; i < NUM_REGS; i++) plan[i] = word_t'(W_MAX);
    apply_plan();
    n_settings++;
    push_req(FN_LOAD, word_t'(W_MAX), word_t'(W_MAX));
    push_req(FN_ITER, '0, '0);
    push_req(FN_LOAD, word_t'(W_MIN), word_t'(W_MIN));
    push_req(FN_ITER, '0, '0);
    wait_idle();

    // all registers at the bottom of the range
    for (int i = 0; i < NUM_REGS; i++) plan[i] = word_t'(W_MIN);
    apply_plan();
    n_settings++;
    push_req(FN_LOAD, word_t'(W_MAX), word_t'(W_MIN));
    push_req(FN_ITER, '0, '0);
    push_req(FN_ITER, '0, '0);
    wait_idle();

    // unit position gain, half velocity gain: truncation toward zero and control clipping both ways
    pendulum_plan();
    plan[RG_P_GAIN] = fx(1, 1);
    plan[RG_D_GAIN] = fx(1, 2);
    apply_plan();
    n_settings++;
    push_req(FN_LOAD, -fx(3, 2), '0);
    push_req(FN_ITER, '0, '0);
    push_req(FN_LOAD, word_t'(W_MAX), word_t'(W_MAX));
    push_req(FN_ITER, '0, '0);
    push_req(FN_LOAD, word_t'(W_MIN), word_t'(W_MIN));
    push_req(FN_ITER, '0, '0);
    wait_idle();

    // writes past the last register must leave the settings alone
    write_reg(8'hFF, word_t'(W_MIN));
    write_reg(CFG_ADDR_W'(NUM_REGS), '1);
    push_req(FN_ITER, '0, '0);
    wait_idle();

    // random phases
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph % 3 == 0) begin
        pendulum_plan();
      end else begin
        for (int i = 0; i < NUM_REGS; i++) plan[i] = rand_coef();
      end
      apply_plan();
      write_reg(CFG_ADDR_W'($urandom_range(NUM_REGS, 255)), $urandom);
      n_settings++;
      set_idling(idle_mode_e'(ph % 4));
      if (ph % 4 == 0) begin
        // receiver holds off while the sender keeps offering
        @(posedge clk_i);
        hold_kick <= 1'b1;
        @(posedge clk_i);
        hold_kick <= 1'b0;
      end
      gen_burst(140);
      // sender pause until the pipeline has emptied
      wait_idle();
      gen_burst(135);
      wait_idle();
    end

    set_idling(IDLE_NONE);
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("covered %0d loads and %0d iterations, %0d results with clipping",
             n_loads, n_iters, n_clipped);
    $display("over %0d register settings and four idle patterns, %0d errors",
             n_settings, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/qpd_pkg.sv
rtl/qpd_if.sv
rtl/qpd_cfg_regs.sv
rtl/qpd_useq.sv
rtl/qpd_datapath.sv
rtl/quantized_pd_map_step_top.sv
tb/tb_quantized_pd_map_step_top.sv
